>>> hdl/psc_pkg.sv
// Shared types and constants of the polyline stroke coverage block.
`default_nettype none
package psc_pkg;

  localparam int MAX_VERTICES = 512;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam int DIV_STEPS    = 16;
  localparam int ROOT_STEPS   = 27;
  localparam int STEP_W       = 5;

  localparam logic [11:0] RADIUS_RESET = 12'd62;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_code_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic take;
    logic fetch_a;
    logic latch_a;
    logic fetch_b;
    logic latch_b;
    logic diff;
    logic mul;
    logic sum;
    logic tsel;
    logic div_step;
    logic tmul;
    logic err;
    logic esq;
    logic min_upd;
    logic root_init;
    logic root_step;
    logic cov;
  } psc_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic count_ge2;
    logic need_div;
    logic seg_more;
  } psc_stat_t;

endpackage
`default_nettype wire

>>> hdl/psc_ctrl.sv
// Sequencer that walks the segments of a query and hands out results.
`default_nettype none
module psc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [1:0]         s_cmd,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  input  wire psc_pkg::psc_stat_t stat,
  output psc_pkg::psc_cmd_t       cmd,
  output logic                    out_load
);

  typedef enum logic [17:0] {
    IDLE      = 18'h00001,
    FETCH_A   = 18'h00002,
    LATCH_A   = 18'h00004,
    FETCH_B   = 18'h00008,
    LATCH_B   = 18'h00010,
    DIFF      = 18'h00020,
    MUL       = 18'h00040,
    SUM       = 18'h00080,
    TSEL      = 18'h00100,
    DIV       = 18'h00200,
    TMUL      = 18'h00400,
    ERR       = 18'h00800,
    ESQ       = 18'h01000,
    MINUPD    = 18'h02000,
    ROOT_INIT = 18'h04000,
    ROOT      = 18'h08000,
    COV       = 18'h10000,
    RESULT    = 18'h20000
  } state_t;

  state_t state, state_next;
  logic [psc_pkg::STEP_W-1:0] step, step_next;
  logic accept;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == RESULT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.take   = accept;
    unique case (state)
      IDLE: begin
        if (accept) begin
          unique case (psc_pkg::cmd_code_t'(s_cmd))
            psc_pkg::CMD_APPEND: state_next = RESULT;
            psc_pkg::CMD_QUERY:  state_next = stat.count_ge2 ? FETCH_A : RESULT;
            psc_pkg::CMD_CLEAR:  state_next = IDLE;
            psc_pkg::CMD_NONE:   state_next = IDLE;
          endcase
        end
      end
      FETCH_A: begin
        cmd.fetch_a = 1'b1;
        state_next  = LATCH_A;
      end
      LATCH_A: begin
        cmd.latch_a = 1'b1;
        state_next  = FETCH_B;
      end
      FETCH_B: begin
        cmd.fetch_b = 1'b1;
        state_next  = LATCH_B;
      end
      LATCH_B: begin
        cmd.latch_b = 1'b1;
        state_next  = DIFF;
      end
      DIFF: begin
        cmd.diff   = 1'b1;
        state_next = MUL;
      end
      MUL: begin
        cmd.mul    = 1'b1;
        state_next = SUM;
      end
      SUM: begin
        cmd.sum    = 1'b1;
        state_next = TSEL;
      end
      TSEL: begin
        cmd.tsel   = 1'b1;
        step_next  = '0;
        state_next = stat.need_div ? DIV : TMUL;
      end
      DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == psc_pkg::STEP_W'(psc_pkg::DIV_STEPS - 1)) begin
          state_next = TMUL;
        end
      end
      TMUL: begin
        cmd.tmul   = 1'b1;
        state_next = ERR;
      end
      ERR: begin
        cmd.err    = 1'b1;
        state_next = ESQ;
      end
      ESQ: begin
        cmd.esq    = 1'b1;
        state_next = MINUPD;
      end
      MINUPD: begin
        cmd.min_upd = 1'b1;
        state_next  = stat.seg_more ? FETCH_B : ROOT_INIT;
      end
      ROOT_INIT: begin
        cmd.root_init = 1'b1;
        step_next     = '0;
        state_next    = ROOT;
      end
      ROOT: begin
        cmd.root_step = 1'b1;
        step_next     = step + 1'b1;
        if (step == psc_pkg::STEP_W'(psc_pkg::ROOT_STEPS - 1)) begin
          state_next = COV;
        end
      end
      COV: begin
        cmd.cov    = 1'b1;
        state_next = RESULT;
      end
      RESULT: begin
        if (out_load) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result word loaded over a pending one");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == DIV) |-> (step < psc_pkg::STEP_W'(psc_pkg::DIV_STEPS)))
    else $error("divider ran past its quotient bits");
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ROOT) |-> (step < psc_pkg::STEP_W'(psc_pkg::ROOT_STEPS)))
    else $error("square root ran past its steps");
  a_query_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == MINUPD) |=> (state == FETCH_B || state == ROOT_INIT))
    else $error("segment walk left the loop in a wrong state");
`endif

endmodule
`default_nettype wire

>>> hdl/psc_datapath.sv
// Vertex store, segment distance unit, divider, square root and result word.
`default_nettype none
module psc_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [33:0]       in_word,
  input  wire logic              cfg_valid,
  input  wire logic [11:0]       cfg_data,
  input  wire psc_pkg::psc_cmd_t cmd,
  input  wire logic              out_load,
  output psc_pkg::psc_stat_t     stat,
  output logic [15:0]            out_word
);

  localparam int AW = psc_pkg::ADDR_W;
  localparam int CW = psc_pkg::CNT_W;

  logic [1:0]         in_cmd;
  logic signed [15:0] in_x, in_y;
  assign in_cmd = in_word[1:0];
  assign in_x   = in_word[17:2];
  assign in_y   = in_word[33:18];

  // State registers
  logic [11:0]   radius;
  logic [CW-1:0] count;
  logic          overflow;
  logic [31:0]   store [psc_pkg::MAX_VERTICES];
  logic [31:0]   rdata;
  logic [AW-1:0] seg, raddr;

  // Query working registers
  logic signed [19:0] qx, qy;
  logic signed [15:0] ax, ay, bx, by;
  logic signed [16:0] dx, dy;
  logic signed [20:0] rx, ry;
  logic signed [33:0] pxx, pyy;
  logic signed [37:0] pnx, pny;
  logic [33:0]        len2;
  logic signed [38:0] num;
  logic [34:0]        rem;
  logic [16:0]        t;
  logic signed [34:0] tdx, tdy;
  logic signed [26:0] ex, ey;
  logic [51:0]        exx, eyy;
  logic [52:0]        best, seg_d2;
  logic [53:0]        rv, rres, rbit;
  logic [7:0]         res_cov;
  logic               res_full;

  logic               full_now;
  logic [34:0]        rem2;
  logic [53:0]        rtry;
  logic signed [39:0] esx, esy;
  logic signed [28:0] cval;
  logic [8:0]         cclamp;
  logic [16:0]        cscaled;

  assign full_now = (count == CW'(psc_pkg::MAX_VERTICES));
  assign raddr    = cmd.fetch_a ? '0 : AW'(seg + 1'b1);

  assign stat.count_ge2 = (count >= CW'(2));
  assign stat.need_div  = (len2 != '0) && (num > 39'sd0) && (num < $signed({5'd0, len2}));
  assign stat.seg_more  = (CW'(seg) + CW'(2)) < count;

  assign rem2   = {rem[33:0], 1'b0};
  assign rtry   = rres + rbit;
  assign seg_d2 = 53'(exx) + 53'(eyy);

  assign esx = 40'sd2048 + 40'(tdx) - (40'(rx) <<< 16);
  assign esy = 40'sd2048 + 40'(tdy) - (40'(ry) <<< 16);

  assign cval    = $signed({13'd0, radius, 4'd0}) + 29'sd128 - $signed({2'd0, rres[26:0]});
  assign cclamp  = (cval < 29'sd0) ? 9'd0 : (cval > 29'sd256) ? 9'd256 : cval[8:0];
  assign cscaled = {cclamp, 8'd0} - 17'(cclamp) + 17'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= psc_pkg::RADIUS_RESET;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      if (cfg_valid) begin
        radius <= cfg_data;
      end
      if (cmd.take) begin
        if (in_cmd == psc_pkg::CMD_CLEAR) begin
          count    <= '0;
          overflow <= 1'b0;
        end else if (in_cmd == psc_pkg::CMD_APPEND) begin
          if (full_now) begin
            overflow <= 1'b1;
          end else begin
            count <= count + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_cmd == psc_pkg::CMD_APPEND && !full_now) begin
      store[count[AW-1:0]] <= {in_y, in_x};
    end
    rdata <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      qx       <= {in_x, 4'd8};
      qy       <= {in_y, 4'd8};
      res_cov  <= '0;
      res_full <= (in_cmd == psc_pkg::CMD_APPEND) ? full_now : overflow;
    end
    if (cmd.fetch_a) begin
      seg  <= '0;
      best <= '1;
    end
    if (cmd.latch_a) begin
      ax <= rdata[15:0];
      ay <= rdata[31:16];
    end
    if (cmd.latch_b) begin
      bx <= rdata[15:0];
      by <= rdata[31:16];
    end
    if (cmd.diff) begin
      dx <= 17'(bx) - 17'(ax);
      dy <= 17'(by) - 17'(ay);
      rx <= 21'(qx) - 21'(ax);
      ry <= 21'(qy) - 21'(ay);
    end
    if (cmd.mul) begin
      pxx <= 34'(dx) * 34'(dx);
      pyy <= 34'(dy) * 34'(dy);
      pnx <= 38'(rx) * 38'(dx);
      pny <= 38'(ry) * 38'(dy);
    end
    if (cmd.sum) begin
      len2 <= 34'(pxx) + 34'(pyy);
      num  <= 39'(pnx) + 39'(pny);
    end
    if (cmd.tsel) begin
      rem <= {1'b0, num[33:0]};
      if (stat.need_div || len2 == '0 || num <= 39'sd0) begin
        t <= '0;
      end else begin
        t <= 17'h10000;
      end
    end
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, len2}) begin
        rem <= rem2 - {1'b0, len2};
        t   <= {t[15:0], 1'b1};
      end else begin
        rem <= rem2;
        t   <= {t[15:0], 1'b0};
      end
    end
    if (cmd.tmul) begin
      tdx <= $signed({18'd0, t}) * 35'(dx);
      tdy <= $signed({18'd0, t}) * 35'(dy);
    end
    if (cmd.err) begin
      ex <= esx[38:12];
      ey <= esy[38:12];
    end
    if (cmd.esq) begin
      exx <= 52'(54'(ex) * 54'(ex));
      eyy <= 52'(54'(ey) * 54'(ey));
    end
    if (cmd.min_upd) begin
      if (seg_d2 < best) begin
        best <= seg_d2;
      end
      seg <= seg + 1'b1;
      ax  <= bx;
      ay  <= by;
    end
    if (cmd.root_init) begin
      rv   <= 54'(best);
      rres <= '0;
      rbit <= 54'(1) << 52;
    end
    if (cmd.root_step) begin
      if (rv >= rtry) begin
        rv   <= rv - rtry;
        rres <= (rres >> 1) + rbit;
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
    end
    if (cmd.cov) begin
      res_cov <= cscaled[15:8];
    end
    if (out_load) begin
      out_word <= {7'd0, res_full, res_cov};
    end
  end

endmodule
`default_nettype wire

>>> hdl/polyline_stroke_coverage.sv
// Top level of the polyline stroke coverage block.
// Usage: words enter on the s_ side; s_tuser holds cmd, s_tdata holds coord_x
// and coord_y. A clear word empties the vertex store and gives no result. An
// append word stores one Q12.4 vertex and returns one result word whose
// store_full bit is set if the store was full and the vertex was dropped. A
// query word names a pixel and returns its stroke coverage 0..255 plus the
// sticky overflow bit. The user must write the stroke radius on the cfg_
// channel only while the block is idle; the block does not enforce this.
// Timing: an append goes straight to its result word, as does a query with
// fewer than two vertices. Otherwise a query walks every segment through the
// one shared segment unit, running its bit-serial divider only for a segment
// whose projection falls strictly inside it, and then takes the bit-serial
// square root of the smallest squared distance. One word is in work at a
// time; s_tready is high only while the sequencer is idle.
// A finished result waits in the output register while m_tready is low, and
// the sequencer holds until that register is free. Reset empties the store,
// clears the overflow bit and sets the radius to 62 (3.875 pixels).
`default_nettype none
module polyline_stroke_coverage (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // coord_x[15:0], coord_y[31:16]
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // coverage[7:0], store_full[8]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data
);

  psc_pkg::psc_cmd_t  cmd;
  psc_pkg::psc_stat_t stat;
  logic               out_load;

  assign cfg_ready = 1'b1;

  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_cmd    (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd),
    .out_load (out_load)
  );

  psc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   ({s_tdata, s_tuser}),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .out_load  (out_load),
    .stat      (stat),
    .out_word  (m_tdata)
  );

endmodule
`default_nettype wire
